// ----- hw/rtl/arsb_pkg.sv -----
// shared types and constants for the scrolling bar display core
package arsb_pkg;

    localparam int COEF_W     = 16;
    localparam int VAL_W      = 16;
    localparam int NOISE_W    = 12;
    localparam int COLOUR_W   = 8;
    localparam int PIXEL_W    = 3 * COLOUR_W;
    localparam int INDEX_W    = 5;
    localparam int NUM_COEFS  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CENTRE_ROW = 2;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int FRAC_DROP  = 14;

    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEFS] =
        '{16'sd6554, -16'sd3277, 16'sd2458, 16'sd1638, 16'sd819};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ACC,
        ST_ROUND,
        ST_ROW,
        ST_WRITE,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic mac_step;
        logic acc_last;
        logic round;
        logic row;
        logic write_step;
        logic load;
        logic take;
    } cmd_t;

    typedef struct packed {
        logic mac_done;
        logic write_done;
        logic emit_last;
    } status_t;

endpackage

// ----- hw/rtl/arsb_ctrl.sv -----
// sequencing state machine for the scrolling bar display core
module arsb_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  arsb_pkg::status_t status,
    output arsb_pkg::cmd_t cmd
);
    import arsb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.mac_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_last = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.row    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_step = 1'b1;
                if (status.write_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.take  = out_ready;
                if (out_ready && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/arsb_datapath.sv -----
// series arithmetic, value history and frame store of the scrolling bar display core
module arsb_datapath
#(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 5,
    parameter int TAPS    = 5
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  arsb_pkg::cmd_t                        cmd,
    output arsb_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [arsb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [arsb_pkg::COEF_W-1:0]           cfg_data,
    input  logic signed [arsb_pkg::NOISE_W-1:0]   noise,
    input  logic [arsb_pkg::COLOUR_W-1:0]         red_in,
    input  logic [arsb_pkg::COLOUR_W-1:0]         green_in,
    input  logic [arsb_pkg::COLOUR_W-1:0]         blue_in,
    output logic [arsb_pkg::INDEX_W-1:0]          pixel_index,
    output logic [arsb_pkg::COLOUR_W-1:0]         red_out,
    output logic [arsb_pkg::COLOUR_W-1:0]         green_out,
    output logic [arsb_pkg::COLOUR_W-1:0]         blue_out,
    output logic signed [arsb_pkg::VAL_W-1:0]     series_value,
    output logic                                  last_pixel
);
    import arsb_pkg::*;

    localparam int PIXELS = ROWS * COLUMNS;
    localparam int AW     = $clog2(PIXELS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int TIW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = PROD_W + 1 + $clog2(TAPS);
    localparam int IDX_WW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int DISP_W = VAL_W + 2;

    // configuration and series state
    logic signed [COEF_W-1:0]   coef_reg [NUM_COEFS];
    logic signed [VAL_W-1:0]    hist_reg [TAPS];
    logic signed [VAL_W-1:0]    value_reg;
    logic signed [NOISE_W-1:0]  noise_reg;
    logic [PIXEL_W-1:0]         colour_reg;

    // multiply-accumulate
    logic [TIW-1:0]             tap_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [COEF_W-1:0]   coef_sel;
    logic signed [VAL_W-1:0]    hist_sel;

    // bar extent
    logic [RW-1:0]              lo_reg;
    logic [RW-1:0]              hi_reg;

    // frame store, columns kept as a ring
    logic [PIXEL_W-1:0]         frame_mem [PIXELS];
    logic [COLUMNS-1:0]         col_valid_reg;
    logic [CW-1:0]              head_reg;
    logic [RW-1:0]              wrow_reg;
    logic [AW-1:0]              wbase_reg;

    // emit cursor
    logic [AW-1:0]              cnt_reg;
    logic [RW-1:0]              erow_reg;
    logic [CW-1:0]              ecol_reg;
    logic [CW-1:0]              epcol_reg;
    logic [AW-1:0]              ebase_reg;
    logic [AW-1:0]              cnt_next;
    logic [RW-1:0]              erow_next;
    logic [CW-1:0]              ecol_next;
    logic [CW-1:0]              epcol_next;
    logic [AW-1:0]              ebase_next;
    logic [AW-1:0]              rd_addr;
    logic [CW-1:0]              rd_pcol;
    logic [PIXEL_W-1:0]         rd_data_reg;
    logic                       rd_ok_reg;

    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [ACC_W-1:0]    q10_sum;
    logic signed [ACC_W-1:0]    v_wide;
    logic signed [VAL_W-1:0]    value_next;
    logic signed [DISP_W-1:0]   v_ext;
    logic signed [DISP_W-1:0]   v3;
    logic signed [DISP_W-1:0]   disp;
    logic signed [DISP_W-1:0]   target;
    logic [RW-1:0]              target_row;
    logic [RW-1:0]              lo_next;
    logic [RW-1:0]              hi_next;
    logic [PIXEL_W-1:0]         wdata;
    logic [IDX_WW-1:0]          idx_wide;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_COEFS; j++)
            begin
                coef_reg[j] <= COEF_RESET[j];
            end
        end
        else if (cfg_we && (int'(cfg_index) < NUM_COEFS))
        begin
            coef_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    // tap selection, lags past the coefficient list weigh zero
    always_comb
    begin
        coef_sel = '0;
        hist_sel = '0;
        for (int j = 0; j < NUM_COEFS; j++)
        begin
            if (int'(tap_reg) == j)
            begin
                coef_sel = coef_reg[j];
            end
        end
        for (int j = 0; j < TAPS; j++)
        begin
            if (int'(tap_reg) == j)
            begin
                hist_sel = hist_reg[j];
            end
        end
    end

    // round half up to q10, add noise, saturate
    always_comb
    begin
        rnd_sum = acc_reg + ACC_W'(8192);
        q10_sum = rnd_sum >>> FRAC_DROP;
        v_wide  = q10_sum + ACC_W'(noise_reg);
        if (v_wide > ACC_W'(32767))
        begin
            value_next = 16'sh7fff;
        end
        else if (v_wide < ACC_W'(-32768))
        begin
            value_next = -16'sh8000;
        end
        else
        begin
            value_next = VAL_W'(v_wide);
        end
    end

    // row offset is value*3/2048 towards zero
    always_comb
    begin
        v_ext = DISP_W'(value_reg);
        v3    = (v_ext <<< 1) + v_ext;
        if (v3 < 0)
        begin
            disp = (v3 + DISP_W'(2047)) >>> 11;
        end
        else
        begin
            disp = v3 >>> 11;
        end
        target = DISP_W'(CENTRE_ROW) - disp;
        if (target < 0)
        begin
            target_row = '0;
        end
        else if (target > DISP_W'(ROWS - 1))
        begin
            target_row = RW'(ROWS - 1);
        end
        else
        begin
            target_row = RW'(target);
        end
        if (int'(target_row) < CENTRE_ROW)
        begin
            lo_next = target_row;
            hi_next = RW'(CENTRE_ROW);
        end
        else
        begin
            lo_next = RW'(CENTRE_ROW);
            hi_next = target_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            for (int j = 0; j < TAPS; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                tap_reg <= '0;
            end
            else if (cmd.mac_step)
            begin
                tap_reg <= tap_reg + TIW'(1);
            end
            if (cmd.round)
            begin
                hist_reg[0] <= value_next;
                for (int j = 1; j < TAPS; j++)
                begin
                    hist_reg[j] <= hist_reg[j-1];
                end
            end
        end
    end

    // item payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            noise_reg  <= noise;
            colour_reg <= {red_in, green_in, blue_in};
            prod_reg   <= '0;
            acc_reg    <= '0;
        end
        if (cmd.mac_step)
        begin
            prod_reg <= coef_sel * hist_sel;
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.acc_last)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.round)
        begin
            value_reg <= value_next;
        end
        if (cmd.row)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign wdata = (wrow_reg >= lo_reg && wrow_reg <= hi_reg) ? colour_reg : '0;

    // new column overwrites the oldest one, then the ring head moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
            head_reg      <= '0;
            wrow_reg      <= '0;
            wbase_reg     <= '0;
        end
        else if (cmd.start)
        begin
            wrow_reg  <= '0;
            wbase_reg <= '0;
        end
        else if (cmd.write_step)
        begin
            wrow_reg  <= wrow_reg + RW'(1);
            wbase_reg <= wbase_reg + AW'(COLUMNS);
            if (int'(wrow_reg) == ROWS - 1)
            begin
                col_valid_reg[head_reg] <= 1'b1;
                head_reg <= (int'(head_reg) == COLUMNS - 1) ? '0 : head_reg + CW'(1);
            end
        end
    end

    // next cursor position in index order
    always_comb
    begin
        cnt_next = cnt_reg + AW'(1);
        if (int'(ecol_reg) == COLUMNS - 1)
        begin
            ecol_next  = '0;
            erow_next  = erow_reg + RW'(1);
            ebase_next = ebase_reg + AW'(COLUMNS);
            epcol_next = head_reg;
        end
        else
        begin
            ecol_next  = ecol_reg + CW'(1);
            erow_next  = erow_reg;
            ebase_next = ebase_reg;
            epcol_next = (int'(epcol_reg) == COLUMNS - 1) ? '0 : epcol_reg + CW'(1);
        end
        if (cmd.load)
        begin
            rd_addr = AW'(head_reg);
            rd_pcol = head_reg;
        end
        else if (cmd.take)
        begin
            rd_addr = ebase_next + AW'(epcol_next);
            rd_pcol = epcol_next;
        end
        else
        begin
            rd_addr = ebase_reg + AW'(epcol_reg);
            rd_pcol = epcol_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            erow_reg  <= '0;
            ecol_reg  <= '0;
            epcol_reg <= '0;
            ebase_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg   <= '0;
            erow_reg  <= '0;
            ecol_reg  <= '0;
            epcol_reg <= head_reg;
            ebase_reg <= '0;
        end
        else if (cmd.take)
        begin
            cnt_reg   <= cnt_next;
            erow_reg  <= erow_next;
            ecol_reg  <= ecol_next;
            epcol_reg <= epcol_next;
            ebase_reg <= ebase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_step)
        begin
            frame_mem[wbase_reg + AW'(head_reg)] <= wdata;
        end
        rd_data_reg <= frame_mem[rd_addr];
        rd_ok_reg   <= col_valid_reg[rd_pcol];
    end

    assign idx_wide     = IDX_WW'(cnt_reg);
    assign pixel_index  = idx_wide[INDEX_W-1:0];
    assign red_out      = rd_ok_reg ? rd_data_reg[PIXEL_W-1:2*COLOUR_W] : '0;
    assign green_out    = rd_ok_reg ? rd_data_reg[2*COLOUR_W-1:COLOUR_W] : '0;
    assign blue_out     = rd_ok_reg ? rd_data_reg[COLOUR_W-1:0] : '0;
    assign series_value = value_reg;
    assign last_pixel   = (int'(cnt_reg) == PIXELS - 1);

    assign status.mac_done   = (int'(tap_reg) == TAPS - 1);
    assign status.write_done = (int'(wrow_reg) == ROWS - 1);
    assign status.emit_last  = last_pixel;

endmodule

// ----- hw/rtl/ar_scrolling_bar_display_core.sv -----
// top level of the autoregressive scrolling bar display core
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    noise, red_in, green_in, blue_in
// m_axis    out  m_axis_tvalid/tready    pixel_index, colours, series_value; tlast
// cfg       in   cfg_we                  cfg_index selects coef_lag1..coef_lag5
//
// one item at a time: multiply-accumulate over the history taps through the single
// 16x16 multiplier, then the final add, round/saturate and row offset, a
// write of the new column row by row through the frame memory write port, a
// read priming step, then ROWS*COLUMNS pixel transfers at up to one per cycle
// while the output is not stalled
// reset clears history, coefficients to their defaults and the column valid
// bits, so an unwritten column reads as off with no clearing pass
// a stalled output transfer holds the pixel; no input is taken until the
// last pixel of the frame has gone
module ar_scrolling_bar_display_core
#(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 5,
    parameter int TAPS    = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,  // noise, red_in, green_in, blue_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_index, red_out, green_out, blue_out, series_value
    output logic [47:0]                    m_axis_tdata,
    output logic                           m_axis_tlast,  // last_pixel
    input  logic                           cfg_we,
    input  logic [arsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arsb_pkg::COEF_W-1:0]    cfg_data
);
    import arsb_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [INDEX_W-1:0]        pixel_index;
    logic [COLOUR_W-1:0]       red_out;
    logic [COLOUR_W-1:0]       green_out;
    logic [COLOUR_W-1:0]       blue_out;
    logic signed [VAL_W-1:0]   series_value;
    logic                      last_pixel;

    // sequencer, sees only the handshakes and datapath status
    arsb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // input fields unpacked from the lowest bit up
    arsb_datapath
    #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .TAPS    (TAPS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .noise        ($signed(s_axis_tdata[11:0])),
        .red_in       (s_axis_tdata[19:12]),
        .green_in     (s_axis_tdata[27:20]),
        .blue_in      (s_axis_tdata[35:28]),
        .pixel_index  (pixel_index),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .series_value (series_value),
        .last_pixel   (last_pixel)
    );

    // output transfer packing, zero padded to whole bytes
    assign m_axis_tdata = {3'b000, series_value, blue_out, green_out, red_out, pixel_index};
    assign m_axis_tlast = last_pixel;

endmodule

// ----- hw/rtl/arsb_checker.sv -----
// port-level checks for the scrolling bar display core, bound to the top level
module arsb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // never takes an item while a frame is going out
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while frame output active");

    // an accepted item needs arithmetic before any pixel appears
    a_no_early_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("pixel shown right after input transfer");

    // the frame ends at the tlast transfer
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output still valid after last pixel");

    // every frame starts at pixel zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[4:0] == 5'd0))
        else $error("frame does not start at pixel zero");

    // stalled pixel holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output transfer changed");

endmodule

bind ar_scrolling_bar_display_core arsb_checker u_arsb_checker (.*);
